/* hdl/slot_id_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Slot ID allocator assertion macros
// Shorthand for the clocked concurrent checks of the allocator top level.
// ----------------------------------------------------------------------------
`ifndef SLOT_ID_ALLOCATOR_MACROS_SVH
`define SLOT_ID_ALLOCATOR_MACROS_SVH

// same-cycle implication on clk, off while rst_n is low
`define SIA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, off while rst_n is low
`define SIA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sia_pkg.sv */
// ----------------------------------------------------------------------------
// Slot ID allocator package
// Field widths, request and status codes, transaction and control structs.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int ID_W      = 6;
  localparam int PAYLOAD_W = 32;
  localparam int DEF_SLOTS = 64;

  // request codes
  localparam logic [1:0] REQ_REGISTER = 2'd0;
  localparam logic [1:0] REQ_RELEASE  = 2'd1;
  localparam logic [1:0] REQ_GET      = 2'd2;
  localparam logic [1:0] REQ_LIST     = 2'd3;

  // status codes
  localparam logic [1:0] STS_OK          = 2'd0;
  localparam logic [1:0] STS_NO_FREE     = 2'd1;
  localparam logic [1:0] STS_NOT_USED    = 2'd2;
  localparam logic [1:0] STS_NONE_ACTIVE = 2'd3;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [ID_W-1:0]      slot_id;
    logic [PAYLOAD_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ID_W-1:0]      slot_id_out;
    logic [PAYLOAD_W-1:0] payload_out;
    logic                 last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_step;
    logic finish;
  } sia_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_list;
    logic out_free;
    logic scan_hit;
    logic pend_valid;
    logic scan_last;
  } sia_sts_t;

endpackage

/* hdl/sia_ctrl.sv */
// ----------------------------------------------------------------------------
// Slot ID allocator controller
// Sequences capture, execute, list scan and list finish for one request.
// ----------------------------------------------------------------------------
module sia_ctrl import sia_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sia_sts_t sts,
  output sia_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.is_list) begin
          state_nxt = ST_SCAN;
        end else if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // hold the scan while a held ID waits for the output register
        if (!(sts.scan_hit && sts.pend_valid && !sts.out_free)) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

/* hdl/sia_dp.sv */
// ----------------------------------------------------------------------------
// Slot ID allocator datapath
// Free stack, payload store, in-use bits, list scan and output register.
// ----------------------------------------------------------------------------
module sia_dp import sia_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  sia_cmd_t  cmd,
  output sia_sts_t  sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = 32;

  // storage
  logic [IDX_W-1:0]     stack_mem [SLOTS];
  logic [PAYLOAD_W-1:0] data_mem  [SLOTS];

  // control state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] wm_r, wm_nxt;
  logic [SLOTS-1:0] in_use_r, in_use_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic             out_valid_r;

  // captured request and read data
  logic [1:0]           req_r;
  logic [ID_W-1:0]      id_r;
  logic [PAYLOAD_W-1:0] pay_r;
  logic                 pris_r;
  logic [IDX_W-1:0]     top_r;
  logic [IDX_W-1:0]     stack_q;
  logic [PAYLOAD_W-1:0] data_q;
  logic [IDX_W-1:0]     pend_r, pend_nxt;
  out_item_t            out_r, out_nxt;

  logic                   out_load;
  logic                   stack_we;
  logic                   data_we;
  logic [CNT_W-1:0]       top_cnt;
  logic [IDX_W-1:0]       top_addr;
  logic [IDX_W-1:0]       push_addr;
  logic [ID_W+IDX_W-1:0]  in_wide;
  logic [ID_W+IDX_W-1:0]  id_wide;
  logic [IDX_W-1:0]       in_idx;
  logic [IDX_W-1:0]       id_idx;
  logic [IDX_W-1:0]       pop_idx;
  logic [ID_W+IDX_W-1:0]  pop_wide;
  logic [ID_W+IDX_W-1:0]  pend_wide;
  logic [ID_W-1:0]        pop_id;
  logic [ID_W-1:0]        pend_id;
  logic [CMP_W-1:0]       id_cmp;
  logic                   id_ok;
  logic                   out_free;

  // stack top; entries below the low-water mark were never overwritten
  assign top_cnt   = count_r - CNT_W'(1);
  assign top_addr  = top_cnt[IDX_W-1:0];
  assign push_addr = count_r[IDX_W-1:0];

  assign in_wide  = {{IDX_W{1'b0}}, in_data.slot_id};
  assign in_idx   = in_wide[IDX_W-1:0];
  assign id_wide  = {{IDX_W{1'b0}}, id_r};
  assign id_idx   = id_wide[IDX_W-1:0];
  assign pop_idx  = pris_r ? top_r : stack_q;
  assign pop_wide = {{ID_W{1'b0}}, pop_idx};
  assign pop_id   = pop_wide[ID_W-1:0];
  assign pend_wide = {{ID_W{1'b0}}, pend_r};
  assign pend_id   = pend_wide[ID_W-1:0];

  assign id_cmp = {{(CMP_W-ID_W){1'b0}}, id_r};
  assign id_ok  = (id_cmp < CMP_W'(SLOTS)) && in_use_r[id_idx];

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_load       = 1'b0;
    out_nxt        = '0;
    out_nxt.status = STS_OK;
    count_nxt      = count_r;
    wm_nxt         = wm_r;
    in_use_nxt     = in_use_r;
    stack_we       = 1'b0;
    data_we        = 1'b0;
    scan_nxt       = scan_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;

    if (cmd.capture) begin
      scan_nxt       = '0;
      pend_valid_nxt = 1'b0;
    end

    if (cmd.exec) begin
      out_load     = 1'b1;
      out_nxt.last = 1'b1;
      case (req_r)
        REQ_REGISTER: begin
          if (count_r == '0) begin
            out_nxt.status = STS_NO_FREE;
          end else begin
            count_nxt           = top_cnt;
            wm_nxt              = (top_cnt < wm_r) ? top_cnt : wm_r;
            in_use_nxt[pop_idx] = 1'b1;
            data_we             = 1'b1;
            out_nxt.slot_id_out = pop_id;
          end
        end
        REQ_RELEASE: begin
          out_nxt.slot_id_out = id_r;
          if (!id_ok || (count_r >= CNT_W'(SLOTS))) begin
            out_nxt.status = STS_NOT_USED;
          end else begin
            in_use_nxt[id_idx] = 1'b0;
            stack_we           = 1'b1;
            count_nxt          = count_r + CNT_W'(1);
          end
        end
        REQ_GET: begin
          out_nxt.slot_id_out = id_r;
          if (!id_ok) begin
            out_nxt.status = STS_NOT_USED;
          end else begin
            out_nxt.payload_out = data_q;
          end
        end
        default: begin
          out_load = 1'b0;
        end
      endcase
    end

    // emit the previously found ID only once a later one proves it is not last
    if (cmd.scan_step) begin
      if (in_use_r[scan_r]) begin
        if (pend_valid_r) begin
          out_load            = 1'b1;
          out_nxt.slot_id_out = pend_id;
        end
        pend_nxt       = scan_r;
        pend_valid_nxt = 1'b1;
      end
      scan_nxt = scan_r + IDX_W'(1);
    end

    if (cmd.finish) begin
      out_load     = 1'b1;
      out_nxt.last = 1'b1;
      if (pend_valid_r) begin
        out_nxt.slot_id_out = pend_id;
      end else begin
        out_nxt.status = STS_NONE_ACTIVE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= CNT_W'(SLOTS);
      wm_r         <= CNT_W'(SLOTS);
      in_use_r     <= '0;
      scan_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      wm_r         <= wm_nxt;
      in_use_r     <= in_use_nxt;
      scan_r       <= scan_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_data.req_type;
      id_r   <= in_data.slot_id;
      pay_r  <= in_data.payload;
      pris_r <= (top_cnt < wm_r);
      top_r  <= top_addr;
    end
    pend_r <= pend_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  // free stack memory
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[push_addr] <= id_idx;
    end
    if (cmd.capture) begin
      stack_q <= stack_mem[top_addr];
    end
  end

  // payload memory
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[pop_idx] <= pay_r;
    end
    if (cmd.capture) begin
      data_q <= data_mem[in_idx];
    end
  end

  assign sts.is_list    = (req_r == REQ_LIST);
  assign sts.out_free   = out_free;
  assign sts.scan_hit   = in_use_r[scan_r];
  assign sts.pend_valid = pend_valid_r;
  assign sts.scan_last  = (scan_r == IDX_W'(SLOTS - 1));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hdl/slot_id_allocator.sv */
// ----------------------------------------------------------------------------
// Slot ID allocator
// Register, release and get: accepted in ST_IDLE, then executed in ST_EXEC once the
//   output register is free, where the result is registered; requests are accepted only in ST_IDLE.
// List: ST_SCAN examines one in-use bit per cycle unless a found ID waits for
//   the output register, then ST_FINISH gives the last result and returns to ST_IDLE.
// Free stack and payload arrays are read once, in the accept cycle.
// Reset: synchronous; all IDs free, none in use, no clearing pass needed.
// ----------------------------------------------------------------------------
`include "slot_id_allocator_macros.svh"

module slot_id_allocator import sia_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  sia_cmd_t cmd;
  sia_sts_t sts;

  sia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sia_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `SIA_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, in_stall, "input not held after accept")
  `SIA_ASSERT_NXT(a_exec_loads_out, cmd.exec, out_valid, "executed request gave no result")
  `SIA_ASSERT_NXT(a_finish_is_last, cmd.finish, out_valid && out_data.last, "list end not last")
  `SIA_ASSERT_IMP(a_load_room, cmd.exec || cmd.finish, !out_valid || !out_stall, "result lost")

endmodule

/* test/tb_slot_id_allocator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot ID allocator testbench
// Sends register, release, get and list requests: a short directed opening,
// then fill, drain and mixed phases with random gaps and output stalls. A
// tracking copy of the free stack, in-use marks and slot payloads predicts
// every reply, and each reply is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_slot_id_allocator import sia_pkg::*; ();

  class slot_alloc_tracker;
    logic [ID_W-1:0]      free_ids [DEF_SLOTS];
    int                   free_cnt;
    bit                   busy [DEF_SLOTS];
    logic [PAYLOAD_W-1:0] stored [DEF_SLOTS];
    out_item_t            pending_replies [$];
    int                   errors;

    function new();
      errors   = 0;
      free_cnt = DEF_SLOTS;
      for (int i = 0; i < DEF_SLOTS; i++) begin
        free_ids[i] = ID_W'(i);
        busy[i]     = 1'b0;
        stored[i]   = '0;
      end
    endfunction

    function out_item_t make_reply(logic [1:0] sts, logic [ID_W-1:0] id,
                                   logic [PAYLOAD_W-1:0] data, logic fin);
      out_item_t r;
      r.status      = sts;
      r.slot_id_out = id;
      r.payload_out = data;
      r.last        = fin;
      return r;
    endfunction

    function void queue_reply(out_item_t r);
      pending_replies.insert(pending_replies.size(), r);
    endfunction

    // Update the tracked state for one accepted transaction and queue its replies.
    function void note_request(in_item_t req);
      logic [ID_W-1:0] id;
      int top;
      id = req.slot_id;
      case (req.req_type)
        REQ_REGISTER: begin
          if (free_cnt == 0) begin
            queue_reply(make_reply(STS_NO_FREE, '0, '0, 1'b1));
          end else begin
            free_cnt--;
            id = free_ids[free_cnt];
            busy[id]   = 1'b1;
            stored[id] = req.payload;
            queue_reply(make_reply(STS_OK, id, '0, 1'b1));
          end
        end
        REQ_RELEASE: begin
          if (!busy[id] || free_cnt >= DEF_SLOTS) begin
            queue_reply(make_reply(STS_NOT_USED, id, '0, 1'b1));
          end else begin
            busy[id] = 1'b0;
            free_ids[free_cnt] = id;
            free_cnt++;
            queue_reply(make_reply(STS_OK, id, '0, 1'b1));
          end
        end
        REQ_GET: begin
          if (!busy[id]) begin
            queue_reply(make_reply(STS_NOT_USED, id, '0, 1'b1));
          end else begin
            queue_reply(make_reply(STS_OK, id, stored[id], 1'b1));
          end
        end
        default: begin
          top = -1;
          for (int i = 0; i < DEF_SLOTS; i++) begin
            if (busy[i]) top = i;
          end
          if (top < 0) begin
            queue_reply(make_reply(STS_NONE_ACTIVE, '0, '0, 1'b1));
          end else begin
            // ascending walk, last flag on the highest busy ID
            for (int i = 0; i <= top; i++) begin
              if (busy[i]) queue_reply(make_reply(STS_OK, ID_W'(i), '0, i == top));
            end
          end
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: status %0d slot_id_out %0d payload_out 0x%08h last %0d",
               got.status, got.slot_id_out, got.payload_out, got.last);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.slot_id_out !== want.slot_id_out) begin
        $error("slot_id_out: expected %0d, actual %0d", want.slot_id_out, got.slot_id_out);
        errors++;
      end
      if (got.payload_out !== want.payload_out) begin
        $error("payload_out: expected 0x%08h, actual 0x%08h",
               want.payload_out, got.payload_out);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  localparam int LIST_CYCLES = DEF_SLOTS + 2;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  slot_alloc_tracker tracker;
  bit tx_burst   = 1'b0;
  bit rx_quiet   = 1'b0;
  int stall_left = 0;

  slot_id_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Result side: check replies at the rising edge, then hold stall for the
  // drawn number of cycles from the next falling edge.
  always begin
    @(posedge clk);
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_result(out_data);
      stall_left = rx_quiet ? 0 : $urandom_range(0, 12);
    end
    @(negedge clk);
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left = stall_left - 1;
  end

  // Pick a busy slot most of the time, otherwise any slot.
  function automatic logic [ID_W-1:0] pick_slot(int busy_pct);
    int ids [$];
    if ($urandom_range(0, 99) < busy_pct) begin
      for (int i = 0; i < DEF_SLOTS; i++) begin
        if (tracker.busy[i]) ids.insert(ids.size(), i);
      end
    end
    if (ids.size() == 0) return ID_W'($urandom_range(0, DEF_SLOTS - 1));
    return ID_W'(ids[$urandom_range(0, ids.size() - 1)]);
  endfunction

  function automatic in_item_t random_request(int w_reg, int w_rel, int w_get);
    in_item_t req;
    int roll;
    roll = $urandom_range(0, 99);
    req.slot_id = ID_W'($urandom_range(0, DEF_SLOTS - 1));
    case ($urandom_range(0, 7))
      0:       req.payload = '0;
      1:       req.payload = '1;
      default: req.payload = $urandom;
    endcase
    if (roll < w_reg) begin
      req.req_type = REQ_REGISTER;
    end else if (roll < w_reg + w_rel) begin
      req.req_type = REQ_RELEASE;
      req.slot_id  = pick_slot(90);
    end else if (roll < w_reg + w_rel + w_get) begin
      req.req_type = REQ_GET;
      req.slot_id  = pick_slot(85);
    end else begin
      req.req_type = REQ_LIST;
    end
    return req;
  endfunction

  task automatic send_request(in_item_t req);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!(in_valid && !in_stall));
    tracker.note_request(req);
  endtask

  task automatic issue(logic [1:0] kind, logic [ID_W-1:0] id, logic [PAYLOAD_W-1:0] data);
    in_item_t req;
    req.req_type = kind;
    req.slot_id  = id;
    req.payload  = data;
    send_request(req);
  endtask

  // Drop valid and hold off until every pending reply has been checked.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_item_t req;
    tracker = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty list, errors on free slots, LIFO reuse, extremes.
    issue(REQ_LIST,     6'd0,  32'h0000_0000);
    issue(REQ_GET,      6'd0,  32'hFFFF_FFFF);
    issue(REQ_RELEASE,  6'd63, 32'h0000_0000);
    issue(REQ_REGISTER, 6'd0,  32'h0000_0000);
    issue(REQ_REGISTER, 6'd63, 32'hFFFF_FFFF);
    issue(REQ_GET,      6'd63, 32'h0000_0000);
    issue(REQ_GET,      6'd62, 32'h0000_0000);
    issue(REQ_LIST,     6'd63, 32'hFFFF_FFFF);
    issue(REQ_RELEASE,  6'd63, 32'h0000_0000);
    issue(REQ_RELEASE,  6'd63, 32'h0000_0000);
    issue(REQ_GET,      6'd63, 32'h0000_0000);
    issue(REQ_REGISTER, 6'd21, 32'hA5A5_5A5A);
    issue(REQ_GET,      6'd63, 32'h0000_0000);
    issue(REQ_RELEASE,  6'd62, 32'h0000_0000);
    issue(REQ_RELEASE,  6'd63, 32'h0000_0000);
    issue(REQ_LIST,     6'd42, 32'h5A5A_A5A5);
    wait_drained();

    // Fill past full, drain past empty, mix, then fill again.
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < 100; n++) begin
        if (n % 16 == 0) begin
          tx_burst = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        case (ph)
          1:       req = random_request(4, 88, 5);
          2:       req = random_request(35, 30, 25);
          default: req = random_request(88, 4, 5);
        endcase
        send_request(req);
      end
      wait_drained();
    end

    repeat (LIST_CYCLES + 20) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb_slot_id_allocator OK");
    end else begin
      $display("tb_slot_id_allocator NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_slot_id_allocator NOT OK");
    $finish;
  end

endmodule
